// File: rtl/lrux_pkg.sv
// ============================================================================
// lrux_pkg: shared types and constants for the LRU store with expiry
// Operation codes, parameter defaults and reset values of the store.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package lrux_pkg;

  // Operation codes carried by an input word.
  typedef enum logic [2:0] {
    OP_LOOKUP = 3'd0,
    OP_STORE  = 3'd1,
    OP_REMOVE = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_TICK   = 3'd4
  } op_t;

  // Parameter defaults.
  localparam int CAPACITY_DEF   = 64;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  // Field widths fixed by the interface.
  localparam int KEY_PORT_W   = 32;
  localparam int VALUE_PORT_W = 32;
  localparam int TTL_W        = 16;
  localparam int TIME_W       = 32;
  localparam int LIMIT_W      = 7;
  localparam int OCC_W        = 7;

  // Reset value of the capacity limit register.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

endpackage : lrux_pkg

`default_nettype wire

// File: rtl/lru_store_with_expiry_top.sv
// ============================================================================
// lru_store_with_expiry_top: fully associative key-value store
// Least-recently-used replacement, per-entry time-to-live and a saturating
// seconds counter advanced by tick words.
// ============================================================================
//
//   Channel | Direction | Handshake          | Word
//   --------+-----------+--------------------+-------------------------------
//   in_     | input     | in_valid/in_ready  | operation, key, value, ttl
//   out_    | output    | out_valid/out_ready| hit, value, evicted, expired,
//           |           |                    | occupancy
//   cfg_    | input     | cfg_valid/cfg_ready| capacity limit
//
// One word per cycle is sustained while results are taken. A word is captured
// in the input register, then the whole associative match, rank update and
// eviction are resolved combinationally into the result register.
// Reset clears all valid bits, the entry count and the time counter at once.
// A stalled result holds the result register and the input register, and
// in_ready drops only when both are full.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lru_store_with_expiry_top
  import lrux_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  // Input channel
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire  [2:0]              in_operation,
  input  wire  [KEY_PORT_W-1:0]   in_key,
  input  wire  [VALUE_PORT_W-1:0] in_store_value,
  input  wire  [TTL_W-1:0]        in_ttl_seconds,
  // Result channel
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic                    out_hit,
  output logic [VALUE_PORT_W-1:0] out_read_value,
  output logic                    out_evicted,
  output logic                    out_expired,
  output logic [OCC_W-1:0]        out_occupancy,
  // Configuration channel
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire  [LIMIT_W-1:0]      cfg_capacity_limit
);

  // Stored widths: the ports carry 32 bits, the store keeps the low bits.
  localparam int KW = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
  localparam int VW = (VALUE_BITS < VALUE_PORT_W) ? VALUE_BITS : VALUE_PORT_W;
  localparam int RW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  // Configuration and global state
  logic [LIMIT_W-1:0] cfg_limit_r;
  logic [TIME_W-1:0]  time_r, time_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;

  // Entry storage
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [KW-1:0]       key_r    [CAPACITY];
  logic [VW-1:0]       value_r  [CAPACITY];
  logic [TIME_W-1:0]   expiry_r [CAPACITY];
  logic [RW-1:0]       rank_r   [CAPACITY];
  logic [RW-1:0]       rank_nxt [CAPACITY];

  // Input register
  logic              s1_valid_r;
  op_t               s1_op_r;
  logic [KW-1:0]     s1_key_r;
  logic [VW-1:0]     s1_val_r;
  logic [TTL_W-1:0]  s1_ttl_r;

  // Result register
  logic                    out_valid_r;
  logic                    out_hit_r, out_hit_nxt;
  logic [VALUE_PORT_W-1:0] out_rv_r, out_rv_nxt;
  logic                    out_evicted_r, out_evicted_nxt;
  logic                    out_expired_r, out_expired_nxt;
  logic [OCC_W-1:0]        out_occ_r;

  // Datapath signals
  logic                advance, proc;
  logic [CAPACITY-1:0] match, keep, free, free_oh, wr_oh;
  logic                hit_any, sel_expd, free_any, need_evict;
  logic [RW-1:0]       sel_rank;
  logic [VW-1:0]       sel_value;
  logic [TIME_W-1:0]   sel_exp, new_exp;
  logic [TIME_W:0]     exp_sum;
  logic [LW-1:0]       lim_raw, lim, lim_m1;
  logic [CW-1:0]       cnt_base;

  // Handshakes: the result register drains or is empty, so the stage moves.
  assign advance   = !out_valid_r || out_ready;
  assign proc      = s1_valid_r && advance;
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_rv_r;
  assign out_evicted    = out_evicted_r;
  assign out_expired    = out_expired_r;
  assign out_occupancy  = out_occ_r;

  // Clamp the capacity limit to 1..CAPACITY.
  always_comb begin
    lim_raw = LW'(cfg_limit_r);
    if (lim_raw == '0) begin
      lim = LW'(1);
    end else if (lim_raw > LW'(CAPACITY)) begin
      lim = LW'(CAPACITY);
    end else begin
      lim = lim_raw;
    end
    lim_m1 = lim - LW'(1);
  end

  // Expiry for a store: zero lifetime never expires, the sum saturates.
  always_comb begin
    exp_sum = {1'b0, time_r} + (TIME_W + 1)'(s1_ttl_r);
    if (s1_ttl_r == '0) begin
      new_exp = '0;
    end else if (exp_sum[TIME_W]) begin
      new_exp = '1;
    end else begin
      new_exp = exp_sum[TIME_W-1:0];
    end
  end

  // Associative match; the matching entry is selected by an AND-OR of lanes.
  always_comb begin
    match     = '0;
    sel_rank  = '0;
    sel_value = '0;
    sel_exp   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i]  = valid_r[i] && (key_r[i] == s1_key_r);
      sel_rank  = sel_rank  | (rank_r[i]   & {RW{match[i]}});
      sel_value = sel_value | (value_r[i]  & {VW{match[i]}});
      sel_exp   = sel_exp   | (expiry_r[i] & {TIME_W{match[i]}});
    end
    hit_any  = |match;
    sel_expd = (sel_exp != '0) && (time_r > sel_exp);
  end

  // Store of a new key: evict every entry at or beyond the limit's last rank,
  // then pick the lowest free slot.
  always_comb begin
    need_evict = (s1_op_r == OP_STORE) && !hit_any && (LW'(cnt_r) >= lim);
    for (int i = 0; i < CAPACITY; i++) begin
      keep[i] = valid_r[i] && !(need_evict && (LW'(rank_r[i]) >= lim_m1));
    end
    free     = ~keep;
    free_oh  = free & (~free + CAPACITY'(1));
    free_any = |free;
    cnt_base = need_evict ? CW'(lim_m1) : cnt_r;
  end

  // Next state of entries and counters, and the result word.
  always_comb begin
    valid_nxt       = valid_r;
    cnt_nxt         = cnt_r;
    time_nxt        = time_r;
    wr_oh           = '0;
    out_hit_nxt     = 1'b0;
    out_rv_nxt      = '0;
    out_evicted_nxt = 1'b0;
    out_expired_nxt = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      rank_nxt[i] = rank_r[i];
    end

    unique case (s1_op_r)
      OP_LOOKUP, OP_REMOVE: begin
        if (hit_any) begin
          if (s1_op_r == OP_LOOKUP && !sel_expd) begin
            // Live lookup hit: move the entry to the front.
            out_hit_nxt = 1'b1;
            out_rv_nxt  = VALUE_PORT_W'(sel_value);
            for (int i = 0; i < CAPACITY; i++) begin
              if (match[i]) begin
                rank_nxt[i] = '0;
              end else if (valid_r[i] && rank_r[i] < sel_rank) begin
                rank_nxt[i] = rank_r[i] + RW'(1);
              end
            end
          end else begin
            // Remove, or a lookup of an expired entry: delete and close ranks.
            out_hit_nxt     = (s1_op_r == OP_REMOVE);
            out_expired_nxt = (s1_op_r == OP_LOOKUP);
            valid_nxt       = valid_r & ~match;
            if (cnt_r != '0) begin
              cnt_nxt = cnt_r - CW'(1);
            end
            for (int i = 0; i < CAPACITY; i++) begin
              if (valid_r[i] && rank_r[i] > sel_rank) begin
                rank_nxt[i] = rank_r[i] - RW'(1);
              end
            end
          end
        end
      end
      OP_STORE: begin
        if (hit_any) begin
          // Existing key: overwrite and move to the front.
          out_hit_nxt = 1'b1;
          wr_oh       = match;
          for (int i = 0; i < CAPACITY; i++) begin
            if (match[i]) begin
              rank_nxt[i] = '0;
            end else if (valid_r[i] && rank_r[i] < sel_rank) begin
              rank_nxt[i] = rank_r[i] + RW'(1);
            end
          end
        end else begin
          // New key: evict as needed, age survivors, insert at the front.
          out_evicted_nxt = need_evict;
          valid_nxt       = keep;
          cnt_nxt         = cnt_base;
          if (free_any) begin
            wr_oh     = free_oh;
            valid_nxt = keep | free_oh;
            cnt_nxt   = cnt_base + CW'(1);
            for (int i = 0; i < CAPACITY; i++) begin
              if (free_oh[i]) begin
                rank_nxt[i] = '0;
              end else if (keep[i]) begin
                rank_nxt[i] = rank_r[i] + RW'(1);
              end
            end
          end
        end
      end
      OP_CLEAR: begin
        valid_nxt = '0;
        cnt_nxt   = '0;
      end
      OP_TICK: begin
        if (time_r != '1) begin
          time_nxt = time_r + TIME_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      cnt_r       <= '0;
      time_r      <= '0;
      cfg_limit_r <= LIMIT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_limit_r <= cfg_capacity_limit;
      end
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (proc) begin
        s1_valid_r <= 1'b0;
      end
      if (proc) begin
        out_valid_r <= 1'b1;
        valid_r     <= valid_nxt;
        cnt_r       <= cnt_nxt;
        time_r      <= time_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r  <= op_t'(in_operation);
      s1_key_r <= in_key[KW-1:0];
      s1_val_r <= in_store_value[VW-1:0];
      s1_ttl_r <= in_ttl_seconds;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (proc) begin
      out_hit_r     <= out_hit_nxt;
      out_rv_r      <= out_rv_nxt;
      out_evicted_r <= out_evicted_nxt;
      out_expired_r <= out_expired_nxt;
      out_occ_r     <= OCC_W'(cnt_nxt);
    end
  end

  // Entry payload and ranks
  always_ff @(posedge clk) begin
    if (proc) begin
      for (int i = 0; i < CAPACITY; i++) begin
        rank_r[i] <= rank_nxt[i];
        if (wr_oh[i]) begin
          key_r[i]    <= s1_key_r;
          value_r[i]  <= s1_val_r;
          expiry_r[i] <= new_exp;
        end
      end
    end
  end

  // The entry count always equals the number of valid entries.
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(cnt_r))
    else $error("entry count differs from number of valid entries");

  // The entry count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= CAPACITY)
    else $error("entry count above capacity");

  // Keys among valid entries are distinct, so at most one entry matches.
  a_match_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $onehot0(match))
    else $error("more than one entry matches the key");

  // A result never reports both a hit and an expiry.
  a_hit_expired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_expired_r))
    else $error("hit and expired both set");

endmodule : lru_store_with_expiry_top

`default_nettype wire

// File: verif/testbench.sv
// ============================================================================
// testbench: self-checking bench for lru_store_with_expiry_top
// A short directed script covers the field extremes, every operation, expiry
// at its exact boundary and the unused operation codes. Random phases follow,
// each under its own capacity limit, with a mostly well-formed key pool.
// Every result word is checked against its typed reply or a model of the store.
// ============================================================================
`timescale 1ns / 1ps

module testbench;
  import lrux_pkg::*;

  localparam int SLOTS           = CAPACITY_DEF;
  localparam int NUM_PHASES      = 10;
  localparam int POOL_MAX        = 80;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int SETTLE_CYCLES   = 8;

  // Operation codes the block must ignore.
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  // One result word as the block reports it.
  typedef struct packed {
    logic                    hit;
    logic [VALUE_PORT_W-1:0] read_value;
    logic                    evicted;
    logic                    expired;
    logic [OCC_W-1:0]        occupancy;
  } store_reply_t;

  // One line of the directed script.
  typedef struct packed {
    logic [2:0]              op;
    logic [KEY_PORT_W-1:0]   key;
    logic [VALUE_PORT_W-1:0] value;
    logic [TTL_W-1:0]        ttl;
    logic                    typed;
    store_reply_t            reply;
  } script_line_t;

  logic                    clk;
  logic                    rst_n          = 1'b0;
  logic                    in_valid       = 1'b0;
  logic                    in_ready;
  logic [2:0]              in_operation   = '0;
  logic [KEY_PORT_W-1:0]   in_key         = '0;
  logic [VALUE_PORT_W-1:0] in_store_value = '0;
  logic [TTL_W-1:0]        in_ttl_seconds = '0;
  logic                    out_valid;
  logic                    out_ready      = 1'b0;
  logic                    out_hit;
  logic [VALUE_PORT_W-1:0] out_read_value;
  logic                    out_evicted;
  logic                    out_expired;
  logic [OCC_W-1:0]        out_occupancy;
  logic                    cfg_valid      = 1'b0;
  logic                    cfg_ready;
  logic [LIMIT_W-1:0]      cfg_capacity_limit = '0;

  lru_store_with_expiry_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_key             (in_key),
    .in_store_value     (in_store_value),
    .in_ttl_seconds     (in_ttl_seconds),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_hit            (out_hit),
    .out_read_value     (out_read_value),
    .out_evicted        (out_evicted),
    .out_expired        (out_expired),
    .out_occupancy      (out_occupancy),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_capacity_limit (cfg_capacity_limit)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Model of the store: slot contents, recency ranks and the seconds counter.
  logic [KEY_PORT_W-1:0]   slot_key    [SLOTS];
  logic [VALUE_PORT_W-1:0] slot_value  [SLOTS];
  logic [TIME_W-1:0]       slot_expiry [SLOTS];
  bit                      slot_live   [SLOTS];
  int                      slot_rank   [SLOTS];
  logic [TIME_W-1:0]       seconds_now   = '0;
  int                      live_count    = 0;
  logic [LIMIT_W-1:0]      limit_setting = LIMIT_RESET;

  store_reply_t pending_replies [$];
  script_line_t script [$];
  store_reply_t oldest_reply;
  int           fault_count       = 0;
  int           idle_cycles       = 0;
  int           sender_burst_left = 0;
  bit           sender_steady     = 1'b0;
  bit           hold_off_pending  = 1'b0;
  logic [KEY_PORT_W-1:0] key_pool [POOL_MAX];
  int           phase_limits [NUM_PHASES] = '{5, 0, 127, 1, 24, 64, 2, 40, 3, 127};

  function automatic int find_slot(input logic [KEY_PORT_W-1:0] key);
    int found;
    found = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (found < 0 && slot_live[i] && slot_key[i] == key) found = i;
    end
    return found;
  endfunction

  // Make a slot the most recent, pushing the younger entries back by one.
  function automatic void touch_slot(input int s);
    int r;
    r = slot_rank[s];
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_live[i] && slot_rank[i] < r) slot_rank[i]++;
    end
    slot_rank[s] = 0;
  endfunction

  // Delete a slot and close the gap it leaves in the ranks.
  function automatic void drop_slot(input int s);
    int r;
    r = slot_rank[s];
    slot_live[s] = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_live[i] && slot_rank[i] > r) slot_rank[i]--;
    end
    if (live_count > 0) live_count--;
  endfunction

  // Expiry time for a lifetime; zero means never, and the sum saturates.
  function automatic logic [TIME_W-1:0] expiry_for(input logic [TTL_W-1:0] ttl);
    logic [TIME_W:0] sum;
    sum = {1'b0, seconds_now} + (TIME_W + 1)'(ttl);
    if (ttl == 0) return '0;
    return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
  endfunction

  // Apply one word to the model and return the result it should produce.
  function automatic store_reply_t lru_predict(input logic [2:0] op,
                                               input logic [KEY_PORT_W-1:0] key,
                                               input logic [VALUE_PORT_W-1:0] value,
                                               input logic [TTL_W-1:0] ttl);
    store_reply_t r;
    int s;
    int victim;
    int lim;
    bit stuck;
    r = '0;
    lim = (limit_setting < 1) ? 1 : ((limit_setting > SLOTS) ? SLOTS : limit_setting);
    stuck = 1'b0;
    case (op)
      OP_LOOKUP: begin
        s = find_slot(key);
        if (s >= 0) begin
          if (slot_expiry[s] != 0 && seconds_now > slot_expiry[s]) begin
            drop_slot(s);
            r.expired = 1'b1;
          end else begin
            touch_slot(s);
            r.hit = 1'b1;
            r.read_value = slot_value[s];
          end
        end
      end
      OP_STORE: begin
        s = find_slot(key);
        if (s >= 0) begin
          r.hit = 1'b1;
          slot_value[s] = value;
          slot_expiry[s] = expiry_for(ttl);
          touch_slot(s);
        end else begin
          // Evict the oldest entries until the new key fits under the limit.
          while (live_count >= lim && live_count > 0 && !stuck) begin
            victim = -1;
            for (int i = 0; i < SLOTS; i++) begin
              if (slot_live[i] && slot_rank[i] == live_count - 1) victim = i;
            end
            if (victim < 0) begin
              stuck = 1'b1;
            end else begin
              drop_slot(victim);
              r.evicted = 1'b1;
            end
          end
          s = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (s < 0 && !slot_live[i]) s = i;
          end
          if (s >= 0) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (slot_live[i]) slot_rank[i]++;
            end
            slot_live[s] = 1'b1;
            slot_key[s] = key;
            slot_value[s] = value;
            slot_expiry[s] = expiry_for(ttl);
            slot_rank[s] = 0;
            live_count++;
          end
        end
      end
      OP_REMOVE: begin
        s = find_slot(key);
        if (s >= 0) begin
          drop_slot(s);
          r.hit = 1'b1;
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) slot_live[i] = 1'b0;
        live_count = 0;
      end
      OP_TICK: begin
        if (seconds_now != '1) seconds_now++;
      end
      default: ;
    endcase
    r.occupancy = live_count[OCC_W-1:0];
    return r;
  endfunction

  // Add a script line; the reply fields count only where typed is set.
  task automatic add_line(input logic [2:0] op, input logic [31:0] key,
                          input logic [31:0] value, input logic [15:0] ttl,
                          input bit typed, input bit hit, input logic [31:0] rd,
                          input bit ev, input bit ex, input int occ);
    script_line_t line;
    line.op = op;
    line.key = key;
    line.value = value;
    line.ttl = ttl;
    line.typed = typed;
    line.reply.hit = hit;
    line.reply.read_value = rd;
    line.reply.evicted = ev;
    line.reply.expired = ex;
    line.reply.occupancy = occ[OCC_W-1:0];
    script.push_back(line);
  endtask

  // Offer one word in bursts with random gaps, then record its result.
  task automatic offer_word(input logic [2:0] op, input logic [KEY_PORT_W-1:0] key,
                            input logic [VALUE_PORT_W-1:0] value,
                            input logic [TTL_W-1:0] ttl,
                            input bit typed, input store_reply_t typed_reply);
    int gap;
    store_reply_t reply;
    gap = 0;
    if (sender_burst_left == 0) begin
      gap = sender_steady ? 0 : $urandom_range(1, 8);
      sender_burst_left = $urandom_range(1, 24);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_key         <= key;
    in_store_value <= value;
    in_ttl_seconds <= ttl;
    do @(posedge clk); while (!in_ready);
    sender_burst_left--;
    reply = lru_predict(op, key, value, ttl);
    pending_replies.push_back(typed ? typed_reply : reply);
  endtask

  // Stop offering and wait until every result word has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] lim);
    cfg_valid          <= 1'b1;
    cfg_capacity_limit <= lim;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    limit_setting = lim;
  endtask

  // Stimulus: directed script, then random phases under several limits.
  initial begin
    logic [2:0]              word_op;
    logic [KEY_PORT_W-1:0]   word_key;
    logic [VALUE_PORT_W-1:0] word_value;
    logic [TTL_W-1:0]        word_ttl;
    int eff_limit;
    int pool_size;
    int pool_cursor;
    int phase_items;
    int lookup_cut;
    int clear_cut;
    int pick;
    for (int i = 0; i < SLOTS; i++) slot_live[i] = 1'b0;

    // Lifetime of one second at time zero: live at second one, gone at two.
    add_line(OP_LOOKUP, 32'h0000_0000, 32'h0, 16'h0,    1, 0, 32'h0, 0, 0, 0);
    add_line(OP_REMOVE, 32'hFFFF_FFFF, 32'h0, 16'h0,    1, 0, 32'h0, 0, 0, 0);
    add_line(OP_STORE,  32'h0000_0000, 32'hFFFF_FFFF, 16'h0,    1, 0, 32'h0, 0, 0, 1);
    add_line(OP_STORE,  32'hFFFF_FFFF, 32'h0, 16'hFFFF, 1, 0, 32'h0, 0, 0, 2);
    add_line(OP_LOOKUP, 32'h0000_0000, 32'h0, 16'h0,    1, 1, 32'hFFFF_FFFF, 0, 0, 2);
    add_line(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 16'h0,    1, 1, 32'h0, 0, 0, 2);
    add_line(OP_STORE,  32'h0000_0000, 32'h5A5A_5A5A, 16'h1, 1, 1, 32'h0, 0, 0, 2);
    add_line(OP_TICK,   32'h0, 32'h0, 16'h0,            1, 0, 32'h0, 0, 0, 2);
    add_line(OP_LOOKUP, 32'h0000_0000, 32'h0, 16'h0,    1, 1, 32'h5A5A_5A5A, 0, 0, 2);
    add_line(OP_TICK,   32'h0, 32'h0, 16'h0,            1, 0, 32'h0, 0, 0, 2);
    add_line(OP_LOOKUP, 32'h0000_0000, 32'h0, 16'h0,    1, 0, 32'h0, 0, 1, 1);
    // Removing an entry that has already expired still reports a hit.
    add_line(OP_STORE,  32'h1234_5678, 32'hA5A5_A5A5, 16'h1, 1, 0, 32'h0, 0, 0, 2);
    add_line(OP_TICK,   32'h0, 32'h0, 16'h0,            1, 0, 32'h0, 0, 0, 2);
    add_line(OP_TICK,   32'h0, 32'h0, 16'h0,            1, 0, 32'h0, 0, 0, 2);
    add_line(OP_REMOVE, 32'h1234_5678, 32'h0, 16'h0,    1, 1, 32'h0, 0, 0, 1);
    // A store over an expired key revives it with the new value.
    add_line(OP_STORE,  32'h0000_00FF, 32'h1, 16'h1,    1, 0, 32'h0, 0, 0, 2);
    add_line(OP_TICK,   32'h0, 32'h0, 16'h0,            0, 0, 32'h0, 0, 0, 0);
    add_line(OP_TICK,   32'h0, 32'h0, 16'h0,            0, 0, 32'h0, 0, 0, 0);
    add_line(OP_STORE,  32'h0000_00FF, 32'h2, 16'h0,    1, 1, 32'h0, 0, 0, 2);
    add_line(OP_LOOKUP, 32'h0000_00FF, 32'h0, 16'h0,    1, 1, 32'h2, 0, 0, 2);
    // Unused codes change nothing, whatever the other fields hold.
    add_line(OP_SPARE_5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1, 0, 32'h0, 0, 0, 2);
    add_line(OP_SPARE_6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1, 0, 32'h0, 0, 0, 2);
    add_line(OP_SPARE_7, 32'h0000_00FF, 32'hFFFF_FFFF, 16'hFFFF, 1, 0, 32'h0, 0, 0, 2);
    add_line(OP_CLEAR,  32'h0, 32'h0, 16'h0,            1, 0, 32'h0, 0, 0, 0);
    add_line(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 16'h0,    1, 0, 32'h0, 0, 0, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[n]) begin
      offer_word(script[n].op, script[n].key, script[n].value, script[n].ttl,
                 script[n].typed, script[n].reply);
    end
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_limit(phase_limits[p][LIMIT_W-1:0]);
      eff_limit = (phase_limits[p] < 1) ? 1 :
                  ((phase_limits[p] > SLOTS) ? SLOTS : phase_limits[p]);
      pool_size = (eff_limit + 12 > POOL_MAX) ? POOL_MAX : eff_limit + 12;
      for (int i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom;
      pool_cursor = 0;
      phase_items = (eff_limit >= 40) ? 240 : 130;
      // Large limits need many stores to fill up, and no clears.
      lookup_cut = (eff_limit >= 40) ? 20 : 30;
      clear_cut  = (eff_limit >= 40) ? 0 : 1;
      // Two phases keep the sender busy while the receiver holds off.
      sender_steady = (p == 1 || p == 6) || ($urandom_range(0, 3) == 0);
      if (p == 1 || p == 6) hold_off_pending = 1'b1;

      for (int n = 0; n < phase_items; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < lookup_cut) word_op = OP_LOOKUP;
        else if (pick < lookup_cut + 8) word_op = OP_REMOVE;
        else if (pick < lookup_cut + 18) word_op = OP_TICK;
        else if (pick < lookup_cut + 20) begin
          case ($urandom_range(0, 2))
            0:       word_op = OP_SPARE_5;
            1:       word_op = OP_SPARE_6;
            default: word_op = OP_SPARE_7;
          endcase
        end else if (pick < lookup_cut + 20 + clear_cut) word_op = OP_CLEAR;
        else word_op = OP_STORE;

        // Keys mostly from the pool; stores often walk it to bring in new keys.
        if ($urandom_range(0, 99) < 6) word_key = $urandom;
        else if (word_op == OP_STORE && $urandom_range(0, 1) == 0) begin
          word_key = key_pool[pool_cursor];
          pool_cursor = (pool_cursor + 1) % pool_size;
        end else word_key = key_pool[$urandom_range(0, pool_size - 1)];

        word_value = ($urandom_range(0, 19) == 0) ? '0 : $urandom;
        pick = $urandom_range(0, 9);
        if (pick < 3) word_ttl = '0;
        else if (pick < 9) word_ttl = TTL_W'($urandom_range(1, 6));
        else word_ttl = TTL_W'($urandom_range(0, 65535));

        offer_word(word_op, word_key, word_value, word_ttl, 1'b0, '0);
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0 && pending_replies.size() == 0) begin
      $display("** lru_store_with_expiry_top: PASSED **");
    end else begin
      $display("** lru_store_with_expiry_top: FAILED **");
    end
    $finish;
  end

  // Receiver: changing stall patterns, with a long hold-off when requested.
  initial begin : receiver
    int stall_pct;
    int pattern_left;
    stall_pct = 0;
    pattern_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(20, 120);
          case ($urandom_range(0, 4))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 25;
            3:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        pattern_left--;
        out_ready <= ($urandom_range(1, 100) > stall_pct);
      end
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: result word with no expectation waiting", $time);
        fault_count++;
      end else begin
        oldest_reply = pending_replies.pop_front();
        if (out_hit !== oldest_reply.hit) begin
          $display("%0t: hit expected %0d actual %0d", $time, oldest_reply.hit, out_hit);
          fault_count++;
        end
        if (out_read_value !== oldest_reply.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time,
                   oldest_reply.read_value, out_read_value);
          fault_count++;
        end
        if (out_evicted !== oldest_reply.evicted) begin
          $display("%0t: evicted expected %0d actual %0d", $time,
                   oldest_reply.evicted, out_evicted);
          fault_count++;
        end
        if (out_expired !== oldest_reply.expired) begin
          $display("%0t: expired expected %0d actual %0d", $time,
                   oldest_reply.expired, out_expired);
          fault_count++;
        end
        if (out_occupancy !== oldest_reply.occupancy) begin
          $display("%0t: occupancy expected %0d actual %0d", $time,
                   oldest_reply.occupancy, out_occupancy);
          fault_count++;
        end
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("** lru_store_with_expiry_top: FAILED **");
        $finish;
      end
    end
  end

endmodule
